>>> hw/rtl/hlb_pkg.sv
// hlb_pkg: shared constants, codes and control structs of the hashed lock bitmap
// no dependencies; used by the interfaces, controller, datapath and top level
package hlb_pkg;

	// field widths fixed by the request and response formats
	localparam int BYTE_W       = 8;
	localparam int SLOT_W       = 12;
	localparam int STATUS_W     = 2;
	localparam int SLOT_COUNT_W = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;

	// hash accumulator width and divider step counter width
	localparam int HASH_W = 32;
	localparam int STEP_W = $clog2(HASH_W);

	localparam logic [HASH_W-1:0] SEED_BERNSTEIN = 32'd5381;
	localparam logic [HASH_W-1:0] SEED_SUM       = 32'd0;
	localparam int                BERN_SHIFT     = 5;
	localparam int                MIN_SLOTS      = 8;

	// hash mode codes
	localparam logic MODE_BERNSTEIN = 1'b0;
	localparam logic MODE_SUM       = 1'b1;

	// request kinds
	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'd1;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED = 2'd0,
		ST_BUSY     = 2'd1,
		ST_RELEASED = 2'd2,
		ST_UNHELD   = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;      // request item accepted this cycle
		logic load;      // load divider with hash magnitude, reseed hash
		logic div_step;  // one remainder bit
		logic read;      // read lock bit at remainder
		logic commit;    // update lock bit and load response register
		logic clear;     // clear one lock bit of the reset sweep
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_done;   // sweep is at its last entry
		logic rsp_blocked;  // response register still held
	} sts_t;

endpackage

>>> hw/rtl/hlb_if.sv
// hlb_if: valid/ready channel interfaces for request items, responses and config writes
// depends on hlb_pkg for field widths
interface hlb_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic                         has_byte;
	logic [hlb_pkg::BYTE_W-1:0]   data_byte;
	logic                         last;

	modport source (output valid, kind, has_byte, data_byte, last, input ready);
	modport sink (input valid, kind, has_byte, data_byte, last, output ready);
endinterface

interface hlb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hlb_pkg::STATUS_W-1:0] status;
	logic [hlb_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, status, slot, input ready);
	modport sink (input valid, status, slot, output ready);
endinterface

interface hlb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hlb_pkg::CFG_IDX_W-1:0]  index;
	logic [hlb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/hlb_ram.sv
// hlb_ram: generic single write port, single read port ram with registered read
// no dependencies
module hlb_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/hlb_ctrl.sv
// hlb_ctrl: request sequencer; reset sweep, byte intake, remainder loop, lock update
// depends on hlb_pkg for command and status structs
module hlb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_last,
	output logic          req_ready,
	input  hlb_pkg::sts_t sts,
	output hlb_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_LOAD  = 6'b000100,
		S_DIV   = 6'b001000,
		S_READ  = 6'b010000,
		S_LOOK  = 6'b100000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [hlb_pkg::STEP_W-1:0] step_q;
	logic                       step_last;

	assign step_last = (step_q == hlb_pkg::STEP_W'(hlb_pkg::HASH_W - 1));
	assign req_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.take = req_valid;
				if (req_valid && req_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_LOOK;
			end
			S_LOOK: begin
				if (!sts.rsp_blocked) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// the remainder loop always runs its full count before the lookup
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && step_last) |=> (state_q == S_READ))
		else $error("divide loop left early or late");

	// no item is taken outside the intake state
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (state_q == S_IDLE))
		else $error("item taken while busy");

endmodule

>>> hw/rtl/hlb_dp.sv
// hlb_dp: hash accumulator, config registers, remainder divider, lock bit ram, response register
// depends on hlb_pkg, hlb_if and hlb_ram
module hlb_dp #(
	parameter int MAX_SLOTS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	hlb_req_if.sink       req,
	hlb_rsp_if.source     rsp,
	hlb_cfg_if.sink       cfg,
	input  hlb_pkg::cmd_t cmd,
	output hlb_pkg::sts_t sts
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam int RW = NW + 1;
	localparam int CW = (NW > hlb_pkg::SLOT_COUNT_W) ? NW : hlb_pkg::SLOT_COUNT_W;
	localparam int SX = (AW > hlb_pkg::SLOT_W) ? AW : hlb_pkg::SLOT_W;
	localparam int HW = hlb_pkg::HASH_W;

	logic                                hash_mode_q;
	logic [hlb_pkg::SLOT_COUNT_W-1:0]    slot_count_q;
	logic [HW-1:0]                       hash_q;
	logic                                kind_q;
	logic [HW-1:0]                       div_q;
	logic [RW-1:0]                       rem_q;
	logic [AW-1:0]                       clr_q;
	logic                                rsp_valid_q;
	hlb_pkg::status_t                    rsp_status_q;
	logic [hlb_pkg::SLOT_W-1:0]          rsp_slot_q;

	logic [HW-1:0]                       byte_ext;
	logic [HW-1:0]                       hash_fold;
	logic [HW-1:0]                       hash_mag;
	logic [HW-1:0]                       seed_cur;
	logic [CW-1:0]                       sc_ext;
	logic [NW-1:0]                       eff_n;
	logic [RW-1:0]                       trial;
	logic [AW-1:0]                       slot_addr;
	logic [SX-1:0]                       slot_ext;
	logic                                lock_bit;
	logic                                ram_wr_en;
	logic [AW-1:0]                       ram_wr_addr;
	logic                                ram_wr_data;
	hlb_pkg::status_t                    status_d;
	logic                                cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	// sign-extended byte folded by the current mode
	assign byte_ext = {{(HW - hlb_pkg::BYTE_W){req.data_byte[hlb_pkg::BYTE_W-1]}},
		req.data_byte};
	always_comb begin
		if (hash_mode_q == hlb_pkg::MODE_SUM) begin
			hash_fold = hash_q + byte_ext;
		end else begin
			hash_fold = (hash_q << hlb_pkg::BERN_SHIFT) + hash_q + byte_ext;
		end
	end

	assign seed_cur = (hash_mode_q == hlb_pkg::MODE_SUM) ? hlb_pkg::SEED_SUM
		: hlb_pkg::SEED_BERNSTEIN;

	// magnitude, with the most negative value read as its unsigned pattern
	assign hash_mag = hash_q[HW-1] ? (~hash_q + 1'b1) : hash_q;

	// slot count clamped to the usable range
	assign sc_ext = CW'(slot_count_q);
	always_comb begin
		if (sc_ext < CW'(hlb_pkg::MIN_SLOTS)) begin
			eff_n = NW'(hlb_pkg::MIN_SLOTS);
		end else if (sc_ext > CW'(MAX_SLOTS)) begin
			eff_n = NW'(MAX_SLOTS);
		end else begin
			eff_n = NW'(sc_ext);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q  <= hlb_pkg::MODE_BERNSTEIN;
			slot_count_q <= hlb_pkg::SLOT_COUNT_W'(4096);
		end else if (cfg_wr) begin
			if (cfg.index == hlb_pkg::REG_HASH_MODE) begin
				hash_mode_q <= cfg.data[0];
			end else if (cfg.index == hlb_pkg::REG_SLOT_COUNT) begin
				slot_count_q <= cfg.data[hlb_pkg::SLOT_COUNT_W-1:0];
			end
		end
	end

	// hash accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= hlb_pkg::SEED_BERNSTEIN;
		end else if (cfg_wr && cfg.index == hlb_pkg::REG_HASH_MODE) begin
			hash_q <= (cfg.data[0] == hlb_pkg::MODE_SUM) ? hlb_pkg::SEED_SUM
				: hlb_pkg::SEED_BERNSTEIN;
		end else if (cmd.load) begin
			hash_q <= seed_cur;
		end else if (cmd.take && req.has_byte) begin
			hash_q <= hash_fold;
		end
	end

	// request kind sampled on the last item
	always_ff @(posedge clk) begin
		if (cmd.take && req.last) begin
			kind_q <= req.kind;
		end
	end

	// restoring remainder, one dividend bit a cycle
	assign trial = {rem_q[RW-2:0], div_q[HW-1]};
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= hash_mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_q << 1;
			if (trial >= RW'(eff_n)) begin
				rem_q <= trial - RW'(eff_n);
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign slot_addr = rem_q[AW-1:0];
	assign slot_ext  = SX'(slot_addr);

	// reset sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign sts.clear_done = (clr_q == AW'(MAX_SLOTS - 1));

	// lock bit store
	assign ram_wr_en   = cmd.clear || cmd.commit;
	assign ram_wr_addr = cmd.clear ? clr_q : slot_addr;
	assign ram_wr_data = cmd.clear ? 1'b0 : (kind_q == hlb_pkg::KIND_ACQUIRE);

	hlb_ram #(
		.WIDTH(1),
		.DEPTH(MAX_SLOTS)
	) u_lock_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (cmd.read),
		.rd_addr(slot_addr),
		.rd_data(lock_bit)
	);

	// test and set or test and clear outcome
	always_comb begin
		if (kind_q == hlb_pkg::KIND_ACQUIRE) begin
			status_d = lock_bit ? hlb_pkg::ST_BUSY : hlb_pkg::ST_ACQUIRED;
		end else begin
			status_d = lock_bit ? hlb_pkg::ST_RELEASED : hlb_pkg::ST_UNHELD;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_status_q <= status_d;
			rsp_slot_q   <= slot_ext[hlb_pkg::SLOT_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.slot        = rsp_slot_q;
	assign sts.rsp_blocked = rsp_valid_q && !rsp.ready;

	// remainder stays below the slot count through the loop
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < RW'(eff_n)))
		else $error("remainder out of range");

	// a commit always presents a response next cycle
	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("response lost after commit");

	// sweep, intake, load and lock update never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.commit, cmd.take, cmd.load}))
		else $error("conflicting datapath commands");

endmodule

>>> hw/rtl/hashed_lock_bitmap.sv
// hashed_lock_bitmap: a request item is taken while idle and its byte, if any, folded into the hash
// an item with last then starts the lookup: load, 32 remainder steps, ram read, update
// the next request item is taken in the cycle after the update, with a waiting response held
// so no item of the next request is taken until the bit-serial remainder loop and update are done
// after reset a sweep clears all MAX_SLOTS lock ram bits, one bit a cycle, before any item
// config is taken in every cycle; hash and slot count reset to seed 5381 and 4096
module hashed_lock_bitmap #(
	parameter int MAX_SLOTS = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	hlb_req_if.sink   req,
	hlb_rsp_if.source rsp,
	hlb_cfg_if.sink   cfg
);

	hlb_pkg::cmd_t cmd;
	hlb_pkg::sts_t sts;

	// sequencer
	hlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_last (req.last),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hash, divider and lock store
	hlb_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for hashed_lock_bitmap, directed tests then random request phases
// depends on hlb_pkg, the hlb_*_if channel interfaces and the hashed_lock_bitmap top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOCK_SLOTS  = 4096;
	localparam int LATENCY     = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                       kind;
		logic                       has_byte;
		logic [hlb_pkg::BYTE_W-1:0] data_byte;
		logic                       last;
	} lock_req_t;

	typedef struct packed {
		hlb_pkg::status_t           status;
		logic [hlb_pkg::SLOT_W-1:0] slot;
	} lock_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	hlb_req_if req_ch ();
	hlb_rsp_if rsp_ch ();
	hlb_cfg_if cfg_ch ();

	hashed_lock_bitmap #(
		.MAX_SLOTS(LOCK_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// predicted block state
	logic [LOCK_SLOTS-1:0]          lock_map;
	logic [hlb_pkg::HASH_W-1:0]     name_hash;
	logic                           hash_mode_q;
	logic [hlb_pkg::CFG_DATA_W-1:0] slot_count_q;
	lock_rsp_t                      pending_grants[$];

	int  errors = 0;
	int  items_sent = 0;
	int  responses_seen = 0;
	int  cycle_count = 0;
	bit  idle_en;
	bit  hold_pending;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [hlb_pkg::HASH_W-1:0] seed_for(input logic mode);
		return (mode == hlb_pkg::MODE_SUM) ? hlb_pkg::SEED_SUM : hlb_pkg::SEED_BERNSTEIN;
	endfunction

	function automatic void report_error(input string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("error: %s", msg);
	endfunction

	function automatic lock_req_t make_item(input logic kind, input logic has_byte,
			input logic [hlb_pkg::BYTE_W-1:0] data_byte, input logic last);
		lock_req_t it;
		it.kind      = kind;
		it.has_byte  = has_byte;
		it.data_byte = data_byte;
		it.last      = last;
		return it;
	endfunction

	// fold one accepted request item into the hash, resolve the lock on the last item
	function automatic void fold_item(input lock_req_t it);
		logic [hlb_pkg::HASH_W-1:0] ext;
		logic [hlb_pkg::HASH_W-1:0] mag;
		int unsigned                slots;
		int unsigned                idx;
		lock_rsp_t                  grant;
		ext = {{(hlb_pkg::HASH_W-hlb_pkg::BYTE_W){it.data_byte[hlb_pkg::BYTE_W-1]}},
			it.data_byte};
		if (it.has_byte) begin
			if (hash_mode_q == hlb_pkg::MODE_SUM)
				name_hash = name_hash + ext;
			else
				name_hash = name_hash * 32'd33 + ext;
		end
		if (!it.last)
			return;
		mag = name_hash[hlb_pkg::HASH_W-1] ? (~name_hash + 32'd1) : name_hash;
		slots = 32'(slot_count_q);
		if (slots < hlb_pkg::MIN_SLOTS)
			slots = hlb_pkg::MIN_SLOTS;
		if (slots > LOCK_SLOTS)
			slots = LOCK_SLOTS;
		idx = mag % slots;
		if (it.kind == hlb_pkg::KIND_ACQUIRE) begin
			if (lock_map[idx]) begin
				grant.status = hlb_pkg::ST_BUSY;
			end else begin
				lock_map[idx] = 1'b1;
				grant.status = hlb_pkg::ST_ACQUIRED;
			end
		end else begin
			if (lock_map[idx]) begin
				lock_map[idx] = 1'b0;
				grant.status = hlb_pkg::ST_RELEASED;
			end else begin
				grant.status = hlb_pkg::ST_UNHELD;
			end
		end
		grant.slot = idx[hlb_pkg::SLOT_W-1:0];
		pending_grants.push_back(grant);
		name_hash = seed_for(hash_mode_q);
	endfunction

	// send one request item, with an optional idle burst ahead of it
	task automatic send_item(input lock_req_t it);
		int gap;
		@(negedge clk);
		gap = (idle_en && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= it.kind;
		req_ch.has_byte  <= it.has_byte;
		req_ch.data_byte <= it.data_byte;
		req_ch.last      <= it.last;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		fold_item(it);
	endtask

	// drop valid and wait until every pending response is back and the block has settled
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input logic [hlb_pkg::CFG_IDX_W-1:0] idx,
			input logic [hlb_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == hlb_pkg::REG_HASH_MODE) begin
			hash_mode_q = value[0];
			name_hash   = seed_for(hash_mode_q);
		end else begin
			slot_count_q = value;
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// byte extremes, a mid-request marker, and a name whose hash is exactly 0x80000000
	task automatic test_byte_extremes();
		logic [hlb_pkg::HASH_W-1:0] r32;
		longint                     rem;
		longint                     w;
		longint                     digit;
		logic [hlb_pkg::BYTE_W-1:0] digits [7];
		int                         i;
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'h00, 1'b0));
		send_item(make_item(hlb_pkg::KIND_RELEASE, 1'b0, 8'hff, 1'b0));
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'h7f, 1'b0));
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'h80, 1'b0));
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'hff, 1'b1));
		// solve seed*33^7 + sum(b_i*33^(6-i)) == 2^31 with balanced base-33 digits
		w = 1;
		repeat (7) w = w * 33;
		r32 = 32'h8000_0000 - 32'(longint'(5381) * w);
		rem = longint'($signed(r32));
		w = w / 33;
		for (i = 0; i < 7; i++) begin
			digit = (rem >= 0) ? (rem + w / 2) / w : -((-rem + w / 2) / w);
			digits[i] = digit[hlb_pkg::BYTE_W-1:0];
			rem = rem - digit * w;
			w = w / 33;
		end
		for (i = 0; i < 7; i++)
			send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, digits[i], i == 6));
	endtask

	// acquire, busy, release, unheld on the empty name
	task automatic test_lock_ops();
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b0, 8'h00, 1'b1));
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b0, 8'h5a, 1'b1));
		send_item(make_item(hlb_pkg::KIND_RELEASE, 1'b0, 8'ha5, 1'b1));
		send_item(make_item(hlb_pkg::KIND_RELEASE, 1'b0, 8'h00, 1'b1));
	endtask

	// a mode write in the middle of a request drops the bytes folded so far
	task automatic test_mode_switch();
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'h12, 1'b0));
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'h34, 1'b0));
		wait_idle();
		write_register(hlb_pkg::REG_HASH_MODE, hlb_pkg::CFG_DATA_W'(hlb_pkg::MODE_SUM));
		send_item(make_item(hlb_pkg::KIND_RELEASE, 1'b1, 8'h85, 1'b1));
		wait_idle();
		write_register(hlb_pkg::REG_HASH_MODE, hlb_pkg::CFG_DATA_W'(hlb_pkg::MODE_BERNSTEIN));
	endtask

	// slot count clamping, odd counts, and lock bits kept across count changes
	task automatic test_slot_count();
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, 13'd8);
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b0, 8'h00, 1'b1));
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, 13'd0);
		send_item(make_item(hlb_pkg::KIND_RELEASE, 1'b0, 8'h00, 1'b1));
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, 13'd8191);
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b0, 8'h00, 1'b1));
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, 13'd13);
		send_item(make_item(hlb_pkg::KIND_ACQUIRE, 1'b1, 8'hc3, 1'b1));
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, 13'd4096);
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure();
		wait_idle();
		hold_pending = 1'b1;
		repeat (10)
			send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 1'b1));
		wait_idle();
	endtask

	// random requests over a small name pool so that slots collide
	task automatic test_random_phase(input logic mode,
			input logic [hlb_pkg::CFG_DATA_W-1:0] count,
			input int n_items, input bit leave_partial);
		logic [hlb_pkg::BYTE_W-1:0] pool_bytes [6][6];
		int                         pool_len [6];
		int                         start;
		int                         pick;
		int                         len;
		int                         k;
		int                         p;
		bit                         closer;
		logic                       kind;
		wait_idle();
		write_register(hlb_pkg::REG_SLOT_COUNT, count);
		write_register(hlb_pkg::REG_HASH_MODE, hlb_pkg::CFG_DATA_W'(mode));
		for (p = 0; p < 6; p++) begin
			pool_len[p] = int'($urandom_range(0, 5));
			for (k = 0; k < 6; k++)
				pool_bytes[p][k] = 8'($urandom_range(0, 255));
		end
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// loose items with any field mix
				repeat ($urandom_range(1, 4))
					send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0));
			end else begin
				pick   = int'($urandom_range(0, 5));
				len    = pool_len[pick];
				kind   = 1'($urandom_range(0, 1));
				closer = (len == 0) || ($urandom_range(0, 5) == 0);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 7) == 0)
						send_item(make_item(kind, 1'b0, 8'($urandom_range(0, 255)), 1'b0));
					send_item(make_item(kind, 1'b1, pool_bytes[pick][k],
						!closer && (k == len - 1)));
				end
				if (closer)
					send_item(make_item(kind, 1'b0, 8'($urandom_range(0, 255)), 1'b1));
			end
		end
		// an unfinished request for the next mode write to drop
		if (leave_partial)
			repeat ($urandom_range(1, 2))
				send_item(make_item(1'($urandom_range(0, 1)), 1'b1,
					8'($urandom_range(0, 255)), 1'b0));
	endtask

	task automatic test_random();
		logic                           phase_mode [9];
		logic [hlb_pkg::CFG_DATA_W-1:0] phase_count [9];
		int                             ph;
		phase_mode  = '{hlb_pkg::MODE_BERNSTEIN, hlb_pkg::MODE_SUM, hlb_pkg::MODE_BERNSTEIN,
			hlb_pkg::MODE_SUM, hlb_pkg::MODE_BERNSTEIN, hlb_pkg::MODE_SUM,
			hlb_pkg::MODE_BERNSTEIN, hlb_pkg::MODE_SUM, hlb_pkg::MODE_BERNSTEIN};
		phase_count = '{13'd8, 13'd8, 13'd16, 13'd13, 13'd4096, 13'd0, 13'd8191, 13'd24, 13'd64};
		for (ph = 0; ph < 9; ph++) begin
			if (ph == 8)
				idle_en = 1'b0;
			test_random_phase(phase_mode[ph], phase_count[ph], 68, ph < 8);
		end
	endtask

	// response ready with idle bursts and the long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// compare each response with the oldest predicted grant
	always @(posedge clk) begin : check_rsp
		lock_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			responses_seen++;
			if (pending_grants.size() == 0) begin
				report_error($sformatf("response %0d unexpected: status %0d slot %0d",
					responses_seen, rsp_ch.status, rsp_ch.slot));
			end else begin
				want = pending_grants.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.slot !== want.slot)
					report_error($sformatf(
						"response %0d: status %0d slot %0d, expected status %0d slot %0d",
						responses_seen, rsp_ch.status, rsp_ch.slot, want.status, want.slot));
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.kind      = hlb_pkg::KIND_ACQUIRE;
		req_ch.has_byte  = 1'b0;
		req_ch.data_byte = '0;
		req_ch.last      = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = hlb_pkg::REG_HASH_MODE;
		cfg_ch.data      = '0;
		idle_en          = 1'b1;
		hold_pending     = 1'b0;
		lock_map         = '0;
		hash_mode_q      = hlb_pkg::MODE_BERNSTEIN;
		slot_count_q     = 13'd4096;
		name_hash        = hlb_pkg::SEED_BERNSTEIN;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_byte_extremes();
		test_lock_ops();
		test_mode_switch();
		test_slot_count();
		test_backpressure();
		test_random();
		wait_idle();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
